@@ rtl/core/tps_pkg.sv @@
// Shared types, constants and vertex-select helpers for the triangle plane slicer.
// No dependencies; used by tps_cross and triangle_plane_slicer_unit.
package tps_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    // product stage plus one quotient bit per stage
    localparam int CROSS_LAT  = COORD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [COORD_BITS-1:0] ucoord_t;
    typedef logic        [1:0]            vidx_t;

    typedef struct packed {
        ucoord_t dh;
        ucoord_t den;
        ucoord_t mag;
        logic    neg;
    } lane_t;

    typedef struct packed {
        logic       hit;
        logic       st_cross;
        logic       en_cross;
        logic [3:0] neg;
        coord_t     base_sx;
        coord_t     base_sz;
        coord_t     base_ex;
        coord_t     base_ez;
    } side_t;

    function automatic vidx_t first_idx(input logic [2:0] m);
        vidx_t r;
        r = 2'd0;
        if (m[0]) begin
            r = 2'd0;
        end else if (m[1]) begin
            r = 2'd1;
        end else if (m[2]) begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic vidx_t second_idx(input logic [2:0] m);
        vidx_t r;
        r = 2'd0;
        if (m[0] && m[1]) begin
            r = 2'd1;
        end else if (m[2] && (m[0] || m[1])) begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic logic [1:0] count3(input logic [2:0] m);
        return {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
    endfunction

    function automatic coord_t pick(input coord_t c0, input coord_t c1, input coord_t c2,
                                    input vidx_t i);
        coord_t r;
        case (i)
            2'd0: r = c0;
            2'd1: r = c1;
            2'd2: r = c2;
            default: r = c0;
        endcase
        return r;
    endfunction

    // Edge setup: s below, b above the plane at h.
    function automatic lane_t lane_calc(input coord_t sc, input coord_t sy,
                                        input coord_t bc, input coord_t by,
                                        input coord_t h);
        lane_t                       l;
        logic signed [COORD_BITS:0] dh_w;
        logic signed [COORD_BITS:0] den_w;
        logic signed [COORD_BITS:0] dd_w;
        logic signed [COORD_BITS:0] mag_w;
        dh_w  = {h[COORD_BITS-1], h} - {sy[COORD_BITS-1], sy};
        den_w = {by[COORD_BITS-1], by} - {sy[COORD_BITS-1], sy};
        dd_w  = {bc[COORD_BITS-1], bc} - {sc[COORD_BITS-1], sc};
        mag_w = dd_w[COORD_BITS] ? -dd_w : dd_w;
        l.dh  = dh_w[COORD_BITS-1:0];
        l.den = den_w[COORD_BITS-1:0];
        l.mag = mag_w[COORD_BITS-1:0];
        l.neg = dd_w[COORD_BITS];
        return l;
    endfunction

endpackage

@@ rtl/core/tps_cross.sv @@
// One crossing lane: registered product dh*mag, then a restoring divider by den,
// one quotient bit per pipeline stage. Depends on tps_pkg.
module tps_cross (
    input  logic            aclk,
    input  logic            en,
    input  tps_pkg::ucoord_t dh,
    input  tps_pkg::ucoord_t mag,
    input  tps_pkg::ucoord_t den,
    output tps_pkg::ucoord_t quo
);
    import tps_pkg::*;

    ucoord_t r_reg [0:COORD_BITS];
    ucoord_t n_reg [0:COORD_BITS];
    ucoord_t d_reg [0:COORD_BITS];
    ucoord_t q_reg [0:COORD_BITS];

    ucoord_t r_next [1:COORD_BITS];
    ucoord_t q_next [1:COORD_BITS];

    logic [PROD_BITS-1:0] prod;
    assign prod = PROD_BITS'(dh) * PROD_BITS'(mag);

    always_comb begin
        logic [COORD_BITS:0] t;
        logic                ge;
        for (int k = 1; k <= COORD_BITS; k++) begin
            t  = {r_reg[k-1], n_reg[k-1][COORD_BITS-1]};
            ge = (t >= {1'b0, d_reg[k-1]});
            t  = ge ? (t - {1'b0, d_reg[k-1]}) : t;
            r_next[k] = t[COORD_BITS-1:0];
            q_next[k] = {q_reg[k-1][COORD_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0] <= prod[PROD_BITS-1:COORD_BITS];
            n_reg[0] <= prod[COORD_BITS-1:0];
            d_reg[0] <= den;
            q_reg[0] <= '0;
            for (int k = 1; k <= COORD_BITS; k++) begin
                r_reg[k] <= r_next[k];
                n_reg[k] <= {n_reg[k-1][COORD_BITS-2:0], 1'b0};
                d_reg[k] <= d_reg[k-1];
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign quo = q_reg[COORD_BITS];

endmodule

@@ rtl/core/triangle_plane_slicer_unit.sv @@
// Triangle / horizontal plane slicer top level: classify, edge setup, four crossing lanes.
// Depends on tps_pkg and tps_cross.
//
// Usage:
//   cfg_we/cfg_wdata write the plane height (signed, reset 0); write it only while
//   no transaction is in flight.
//   Input channel s_*: one triangle per transaction (three vertices, x/y/z each).
//   Output channel m_*: one result per triangle, in order: m_hit and the segment
//   ends (start_x, start_z, end_x, end_z); all ends are zero on a miss.
// Throughput: one triangle per cycle while the output is not held by m_ready.
// Pipeline from input accept to m_valid: input register, classify/setup register,
//   product register, one restoring-divider stage per quotient bit, output register.
// Stall: the whole pipeline advances only when the output register is empty or
//   being taken; s_ready follows that, so nothing is dropped or repeated.
// Reset: synchronous, active-low aresetn clears all valid bits and the height;
//   s_ready is low while reset is held.
module triangle_plane_slicer_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  tps_pkg::coord_t cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  tps_pkg::coord_t s_v0_x,
    input  tps_pkg::coord_t s_v0_y,
    input  tps_pkg::coord_t s_v0_z,
    input  tps_pkg::coord_t s_v1_x,
    input  tps_pkg::coord_t s_v1_y,
    input  tps_pkg::coord_t s_v1_z,
    input  tps_pkg::coord_t s_v2_x,
    input  tps_pkg::coord_t s_v2_y,
    input  tps_pkg::coord_t s_v2_z,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_hit,
    output tps_pkg::coord_t m_start_x,
    output tps_pkg::coord_t m_start_z,
    output tps_pkg::coord_t m_end_x,
    output tps_pkg::coord_t m_end_z
);
    import tps_pkg::*;

    logic adv;

    coord_t h_reg;

    logic   a_valid_reg;
    coord_t a_x0_reg, a_y0_reg, a_z0_reg;
    coord_t a_x1_reg, a_y1_reg, a_z1_reg;
    coord_t a_x2_reg, a_y2_reg, a_z2_reg;

    logic  sd_valid_reg [0:CROSS_LAT];
    side_t sd_reg       [0:CROSS_LAT];
    lane_t ln_reg       [0:3];

    side_t side_next;
    lane_t ln_next [0:3];

    ucoord_t quo [0:3];

    logic   m_valid_reg;
    logic   m_hit_reg;
    coord_t m_sx_reg, m_sz_reg, m_ex_reg, m_ez_reg;
    logic   m_hit_next;
    coord_t m_sx_next, m_sz_next, m_ex_next, m_ez_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv && aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= '0;
        end else if (cfg_we) begin
            h_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_x0_reg <= s_v0_x; a_y0_reg <= s_v0_y; a_z0_reg <= s_v0_z;
            a_x1_reg <= s_v1_x; a_y1_reg <= s_v1_y; a_z1_reg <= s_v1_z;
            a_x2_reg <= s_v2_x; a_y2_reg <= s_v2_y; a_z2_reg <= s_v2_z;
        end
    end

    // classify and edge setup
    always_comb begin
        logic [2:0] lo, hi, on;
        logic [1:0] nlo, nhi, non;
        logic       c_one_lo, c_two_lo, c_on_one, c_on_two;
        vidx_t      lo0, lo1, hi0, hi1, on0, on1, sa, ba, sb, bb;
        lo[0] = a_y0_reg < h_reg;  hi[0] = a_y0_reg > h_reg;
        lo[1] = a_y1_reg < h_reg;  hi[1] = a_y1_reg > h_reg;
        lo[2] = a_y2_reg < h_reg;  hi[2] = a_y2_reg > h_reg;
        on  = ~(lo | hi);
        nlo = count3(lo);
        nhi = count3(hi);
        non = count3(on);
        c_one_lo = (non == 2'd0) && (nlo == 2'd1) && (nhi == 2'd2);
        c_two_lo = (non == 2'd0) && (nlo == 2'd2) && (nhi == 2'd1);
        c_on_one = (non == 2'd1) && (nlo == 2'd1) && (nhi == 2'd1);
        c_on_two = (non == 2'd2);
        lo0 = first_idx(lo);  lo1 = second_idx(lo);
        hi0 = first_idx(hi);  hi1 = second_idx(hi);
        on0 = first_idx(on);  on1 = second_idx(on);
        sa = lo0;
        ba = hi0;
        sb = c_two_lo ? lo1 : lo0;
        bb = c_one_lo ? hi1 : hi0;

        ln_next[0] = lane_calc(pick(a_x0_reg, a_x1_reg, a_x2_reg, sa),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, sa),
                               pick(a_x0_reg, a_x1_reg, a_x2_reg, ba),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, ba), h_reg);
        ln_next[1] = lane_calc(pick(a_z0_reg, a_z1_reg, a_z2_reg, sa),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, sa),
                               pick(a_z0_reg, a_z1_reg, a_z2_reg, ba),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, ba), h_reg);
        ln_next[2] = lane_calc(pick(a_x0_reg, a_x1_reg, a_x2_reg, sb),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, sb),
                               pick(a_x0_reg, a_x1_reg, a_x2_reg, bb),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, bb), h_reg);
        ln_next[3] = lane_calc(pick(a_z0_reg, a_z1_reg, a_z2_reg, sb),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, sb),
                               pick(a_z0_reg, a_z1_reg, a_z2_reg, bb),
                               pick(a_y0_reg, a_y1_reg, a_y2_reg, bb), h_reg);

        side_next.hit      = c_one_lo || c_two_lo || c_on_one || c_on_two;
        side_next.st_cross = c_one_lo || c_two_lo;
        side_next.en_cross = c_one_lo || c_two_lo || c_on_one;
        side_next.neg      = {ln_next[3].neg, ln_next[2].neg, ln_next[1].neg, ln_next[0].neg};
        side_next.base_sx  = '0;
        side_next.base_sz  = '0;
        side_next.base_ex  = '0;
        side_next.base_ez  = '0;
        if (side_next.hit) begin
            side_next.base_sx = side_next.st_cross ? pick(a_x0_reg, a_x1_reg, a_x2_reg, sa)
                                                   : pick(a_x0_reg, a_x1_reg, a_x2_reg, on0);
            side_next.base_sz = side_next.st_cross ? pick(a_z0_reg, a_z1_reg, a_z2_reg, sa)
                                                   : pick(a_z0_reg, a_z1_reg, a_z2_reg, on0);
            side_next.base_ex = side_next.en_cross ? pick(a_x0_reg, a_x1_reg, a_x2_reg, sb)
                                                   : pick(a_x0_reg, a_x1_reg, a_x2_reg, on1);
            side_next.base_ez = side_next.en_cross ? pick(a_z0_reg, a_z1_reg, a_z2_reg, sb)
                                                   : pick(a_z0_reg, a_z1_reg, a_z2_reg, on1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= CROSS_LAT; k++) begin
                sd_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            sd_valid_reg[0] <= a_valid_reg;
            for (int k = 1; k <= CROSS_LAT; k++) begin
                sd_valid_reg[k] <= sd_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= side_next;
            for (int k = 1; k <= CROSS_LAT; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
            for (int j = 0; j < 4; j++) begin
                ln_reg[j] <= ln_next[j];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        tps_cross u_cross (
            .aclk (aclk),
            .en   (adv),
            .dh   (ln_reg[g].dh),
            .mag  (ln_reg[g].mag),
            .den  (ln_reg[g].den),
            .quo  (quo[g])
        );
    end

    always_comb begin
        side_t   sd;
        ucoord_t t0, t1, t2, t3;
        sd = sd_reg[CROSS_LAT];
        t0 = sd.neg[0] ? ucoord_t'(sd.base_sx) - quo[0] : ucoord_t'(sd.base_sx) + quo[0];
        t1 = sd.neg[1] ? ucoord_t'(sd.base_sz) - quo[1] : ucoord_t'(sd.base_sz) + quo[1];
        t2 = sd.neg[2] ? ucoord_t'(sd.base_ex) - quo[2] : ucoord_t'(sd.base_ex) + quo[2];
        t3 = sd.neg[3] ? ucoord_t'(sd.base_ez) - quo[3] : ucoord_t'(sd.base_ez) + quo[3];
        m_hit_next = sd.hit;
        m_sx_next  = sd.st_cross ? coord_t'(t0) : sd.base_sx;
        m_sz_next  = sd.st_cross ? coord_t'(t1) : sd.base_sz;
        m_ex_next  = sd.en_cross ? coord_t'(t2) : sd.base_ex;
        m_ez_next  = sd.en_cross ? coord_t'(t3) : sd.base_ez;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= sd_valid_reg[CROSS_LAT];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_hit_reg <= m_hit_next;
            m_sx_reg  <= m_sx_next;
            m_sz_reg  <= m_sz_next;
            m_ex_reg  <= m_ex_next;
            m_ez_reg  <= m_ez_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_hit     = m_hit_reg;
    assign m_start_x = m_sx_reg;
    assign m_start_z = m_sz_reg;
    assign m_end_x   = m_ex_reg;
    assign m_end_z   = m_ez_reg;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_start_x == '0 && m_start_z == '0 &&
                              m_end_x == '0 && m_end_z == '0)
        else $error("miss transaction with nonzero ends");

    a_miss_no_cross: assert property (@(posedge aclk) disable iff (!aresetn)
        sd_valid_reg[0] && !sd_reg[0].hit |-> !sd_reg[0].st_cross && !sd_reg[0].en_cross)
        else $error("crossing flagged on a miss");

    a_in_to_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && adv |=> sd_valid_reg[0])
        else $error("transaction lost between input and setup stage");
`endif

endmodule

@@ bench/triangle_plane_slicer_unit_test.sv @@
// Self-checking testbench for triangle_plane_slicer_unit: random and directed triangles,
// predicted segment checked per transaction. Depends on tps_pkg and the slicer RTL.
module triangle_plane_slicer_unit_test;
    import tps_pkg::*;

    typedef struct {
        coord_t x[3];
        coord_t y[3];
        coord_t z[3];
    } tri_t;

    typedef struct {
        logic   hit;
        coord_t sx;
        coord_t sz;
        coord_t ex;
        coord_t ez;
    } segment_t;

    localparam coord_t CMAX = coord_t'(24'h7fffff);
    localparam coord_t CMIN = coord_t'(24'h800000);
    localparam int STALL_LIMIT = 5000;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   cfg_we = 1'b0;
    coord_t cfg_wdata = '0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_v0_x = '0, s_v0_y = '0, s_v0_z = '0;
    coord_t s_v1_x = '0, s_v1_y = '0, s_v1_z = '0;
    coord_t s_v2_x = '0, s_v2_y = '0, s_v2_z = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_hit;
    coord_t m_start_x, m_start_z, m_end_x, m_end_z;

    coord_t   plane_h = '0;
    segment_t segments_due[$];
    int       fails = 0;
    int       s_idle_pct = 37;
    int       m_idle_pct = 81;
    int       quiet_cycles = 0;

    triangle_plane_slicer_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_v0_x(s_v0_x), .s_v0_y(s_v0_y), .s_v0_z(s_v0_z),
        .s_v1_x(s_v1_x), .s_v1_y(s_v1_y), .s_v1_z(s_v1_z),
        .s_v2_x(s_v2_x), .s_v2_y(s_v2_y), .s_v2_z(s_v2_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_start_x(m_start_x), .m_start_z(m_start_z),
        .m_end_x(m_end_x), .m_end_z(m_end_z)
    );

    always #5 aclk = ~aclk;

    function automatic longint edge_point(longint sc, longint sy, longint bc, longint by,
                                          longint h);
        longint unsigned dh, den, mag, q;
        longint dd;
        dh  = longint'(h - sy);
        den = longint'(by - sy);
        dd  = bc - sc;
        mag = dd < 0 ? -dd : dd;
        if (den == 0) begin
            return sc;
        end
        q = (dh * mag) / den;
        return dd < 0 ? sc - longint'(q) : sc + longint'(q);
    endfunction

    function automatic segment_t slice(tri_t t, coord_t hc);
        segment_t r;
        longint h, x[3], y[3], z[3];
        int lo[3], hi[3], on[3];
        int nlo, nhi, non;
        nlo = 0; nhi = 0; non = 0;
        h = longint'(hc);
        r = '{1'b0, '0, '0, '0, '0};
        for (int i = 0; i < 3; i++) begin
            x[i] = longint'(t.x[i]); y[i] = longint'(t.y[i]); z[i] = longint'(t.z[i]);
            if (y[i] < h) begin
                lo[nlo] = i;
                nlo++;
            end else if (y[i] > h) begin
                hi[nhi] = i;
                nhi++;
            end else begin
                on[non] = i;
                non++;
            end
        end
        if (non == 0 && nlo == 1) begin
            r.hit = 1'b1;
            r.sx = coord_t'(edge_point(x[lo[0]], y[lo[0]], x[hi[0]], y[hi[0]], h));
            r.sz = coord_t'(edge_point(z[lo[0]], y[lo[0]], z[hi[0]], y[hi[0]], h));
            r.ex = coord_t'(edge_point(x[lo[0]], y[lo[0]], x[hi[1]], y[hi[1]], h));
            r.ez = coord_t'(edge_point(z[lo[0]], y[lo[0]], z[hi[1]], y[hi[1]], h));
        end else if (non == 0 && nlo == 2) begin
            r.hit = 1'b1;
            r.sx = coord_t'(edge_point(x[lo[0]], y[lo[0]], x[hi[0]], y[hi[0]], h));
            r.sz = coord_t'(edge_point(z[lo[0]], y[lo[0]], z[hi[0]], y[hi[0]], h));
            r.ex = coord_t'(edge_point(x[lo[1]], y[lo[1]], x[hi[0]], y[hi[0]], h));
            r.ez = coord_t'(edge_point(z[lo[1]], y[lo[1]], z[hi[0]], y[hi[0]], h));
        end else if (non == 1 && nlo == 1) begin
            r.hit = 1'b1;
            r.sx = coord_t'(x[on[0]]);
            r.sz = coord_t'(z[on[0]]);
            r.ex = coord_t'(edge_point(x[lo[0]], y[lo[0]], x[hi[0]], y[hi[0]], h));
            r.ez = coord_t'(edge_point(z[lo[0]], y[lo[0]], z[hi[0]], y[hi[0]], h));
        end else if (non == 2) begin
            r.hit = 1'b1;
            r.sx = coord_t'(x[on[0]]);
            r.sz = coord_t'(z[on[0]]);
            r.ex = coord_t'(x[on[1]]);
            r.ez = coord_t'(z[on[1]]);
        end
        return r;
    endfunction

    task automatic report(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fails++;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        segment_t e;
        if (aresetn && m_valid && m_ready) begin
            if (segments_due.size() == 0) begin
                report("unexpected transaction", 24'(m_hit), 24'h0);
            end else begin
                e = segments_due.pop_front();
                if (m_hit !== e.hit) report("hit", 24'(m_hit), 24'(e.hit));
                if (m_start_x !== e.sx) report("start_x", m_start_x, e.sx);
                if (m_start_z !== e.sz) report("start_z", m_start_z, e.sz);
                if (m_end_x !== e.ex) report("end_x", m_end_x, e.ex);
                if (m_end_z !== e.ez) report("end_z", m_end_z, e.ez);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("triangle_plane_slicer_unit regression: fail");
            $finish;
        end
    end

    task automatic send(tri_t t);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_v0_x <= t.x[0]; s_v0_y <= t.y[0]; s_v0_z <= t.z[0];
        s_v1_x <= t.x[1]; s_v1_y <= t.y[1]; s_v1_z <= t.z[1];
        s_v2_x <= t.x[2]; s_v2_y <= t.y[2]; s_v2_z <= t.z[2];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        segments_due.insert(segments_due.size(), slice(t, plane_h));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge aclk);
        repeat (CROSS_LAT + 5) @(posedge aclk);
    endtask

    task automatic set_height(coord_t h);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= h;
        @(posedge aclk);
        cfg_we <= 1'b0;
        plane_h = h;
    endtask

    function automatic tri_t make_tri(coord_t y0, coord_t y1, coord_t y2);
        tri_t t;
        t.y = '{y0, y1, y2};
        for (int i = 0; i < 3; i++) begin
            t.x[i] = coord_t'($urandom);
            t.z[i] = coord_t'($urandom);
        end
        return t;
    endfunction

    function automatic coord_t pick_y(coord_t h);
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return h;
            2: return h + coord_t'($urandom_range(0, 6)) - coord_t'(3);
            default: return h + coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
        endcase
    endfunction

    task automatic test_cases();
        tri_t t;
        set_height('0);
        send(make_tri(24'sd10, 24'sd20, 24'sd30));
        send(make_tri(-24'sd10, -24'sd20, -24'sd30));
        send(make_tri('0, '0, '0));
        send(make_tri('0, 24'sd5, 24'sd9));
        send(make_tri(-24'sd4, '0, -24'sd9));
        send(make_tri(-24'sd4, '0, 24'sd9));
        send(make_tri('0, 24'sd7, '0));
        send(make_tri('0, '0, -24'sd7));
        send(make_tri(-24'sd5, 24'sd6, 24'sd7));
        send(make_tri(24'sd5, -24'sd6, 24'sd7));
        send(make_tri(24'sd5, 24'sd6, -24'sd7));
        send(make_tri(-24'sd5, -24'sd6, 24'sd7));
        send(make_tri(-24'sd5, 24'sd6, -24'sd7));
        send(make_tri(24'sd5, -24'sd6, -24'sd7));
        t.y = '{CMIN, CMAX, 24'sd1};
        t.x = '{CMIN, CMAX, CMIN};
        t.z = '{CMAX, CMIN, CMAX};
        send(t);
        t.y = '{CMAX, CMIN, 24'sd0};
        t.x = '{CMAX, CMIN, CMAX};
        t.z = '{CMIN, CMAX, 24'sd0};
        send(t);
        t.y = '{-24'sd1, CMAX, CMAX};
        send(t);
    endtask

    task automatic test_height_extremes();
        set_height(CMAX);
        send(make_tri(CMAX, CMIN, '0));
        send(make_tri(CMAX, CMAX, 24'sd5));
        send(make_tri(CMAX, CMAX, CMAX));
        send(make_tri(CMIN, '0, -24'sd1));
        set_height(CMIN);
        send(make_tri(CMIN, CMAX, '0));
        send(make_tri(CMIN, CMIN, CMAX));
        send(make_tri(CMIN, 24'sd3, CMIN));
        send(make_tri(24'sd5, 24'sd6, 24'sd7));
    endtask

    task automatic test_random(int n, int s_pct, int m_pct);
        drain();
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
        for (int i = 0; i < n; i++) begin
            if (i % 45 == 0) set_height(($urandom_range(0, 3) == 0) ? '0 : coord_t'($urandom));
            send(make_tri(pick_y(plane_h), pick_y(plane_h), pick_y(plane_h)));
        end
    endtask

    task automatic test_pause_until_empty();
        for (int i = 0; i < 12; i++) begin
            send(make_tri(pick_y(plane_h), pick_y(plane_h), pick_y(plane_h)));
        end
        s_valid <= 1'b0;
        while (segments_due.size() != 0) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            send(make_tri(pick_y(plane_h), pick_y(plane_h), pick_y(plane_h)));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_cases();
        test_height_extremes();
        test_random(130, 37, 81);
        test_pause_until_empty();
        test_random(130, 81, 37);
        test_random(130, 0, 0);
        drain();
        if (fails == 0) begin
            $display("triangle_plane_slicer_unit regression: pass");
        end else begin
            $display("triangle_plane_slicer_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ triangle_plane_slicer_unit.f @@
rtl/core/tps_pkg.sv
rtl/core/tps_cross.sv
rtl/core/triangle_plane_slicer_unit.sv
bench/triangle_plane_slicer_unit_test.sv
